[rtl/core/free_list_pool_allocator_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the pool allocator
// Shared forms for concurrent checks sampled on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef FREE_LIST_POOL_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_POOL_ALLOCATOR_ASSERT_SVH

// check that is switched off while reset is high
`define FLPA_ASSERT(lbl, rst, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define FLPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/flpa_pkg.sv]
// ---------------------------------------------------------------------------
// flpa_pkg
// Types, codes and constants shared by the pool allocator modules.
// ---------------------------------------------------------------------------
package flpa_pkg;

   // pool depth default and the largest pool the 8-bit index can address
   localparam int POOL_DEPTH_DEF = 256;
   localparam int RANGE_HIGH     = 256;
   localparam int MIN_POOL       = 2;

   // command codes on the request channel
   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   // status codes on the response channel
   localparam logic [1:0] STS_OK           = 2'd0;
   localparam logic [1:0] STS_EMPTY        = 2'd1;
   localparam logic [1:0] STS_ALREADY_FREE = 2'd2;
   localparam logic [1:0] STS_RANGE        = 2'd3;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_NONE,
      OP_INIT,
      OP_ALLOC,
      OP_FREE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] index;
   } work_type;

   typedef struct packed {
      logic [8:0] active_count;
      logic [8:0] free_count;
      logic [7:0] index;
      logic [1:0] status;
   } result_type;

endpackage

[rtl/core/free_list_pool_allocator.sv]
// ---------------------------------------------------------------------------
// free_list_pool_allocator
// Fixed-size entry pool kept as a LIFO free list of entry indices.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one command per item: init, allocate or free.
//   rsp channel returns exactly one result item per command, in order, with
//   the status, the allocated index and the free and active counts.
//   csr channel writes item_count, the pool size used by the next init; it
//   is always ready; the user must write it only while idle (not enforced).
// Operation:
//   Accepted items wait in a two-entry queue. Init, unused commands, allocate
//   on an empty pool and out-of-range frees are decided in the idle state, and
//   their result is registered as they leave the queue. Allocate and in-range
//   free first read the next-link or free-mark memory through its registered
//   read port, then give their result from S_ALLOC or S_FREE. Init then
//   relinks the pool, one entry a cycle, and takes no new item meanwhile.
// Reset:
//   Synchronous reset rebuilds the full pool of min(POOL_DEPTH, 256) entries
//   with the same relink pass; req_tready stays low throughout the pass.
// Stall:
//   A held result waits in the output register; the queue keeps taking
//   items until it holds two.
// ---------------------------------------------------------------------------
module free_list_pool_allocator #(
   parameter int POOL_DEPTH = flpa_pkg::POOL_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] command, [9:2] entry_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [9:2] entry_index_res, [18:10] free_count,
   // [27:19] active_count
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data     // item_count
);
   import flpa_pkg::*;

   logic     q_valid;
   work_type q_item;
   logic     q_pop;
   logic     sweeping;

   flpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .sweeping   (sweeping),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   flpa_back #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .sweeping   (sweeping),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/flpa_front.sv]
// ---------------------------------------------------------------------------
// flpa_front
// Request intake: decodes each command and holds it in a two-entry queue.
// ---------------------------------------------------------------------------
module flpa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [1:0] command, [9:2] entry_index
   input  logic                sweeping,
   output logic                q_valid,
   output flpa_pkg::work_type  q_item,
   input  logic                q_pop
);
   import flpa_pkg::*;

   work_type   slot_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       accept;
   work_type   item;

   // classify the command
   always_comb begin
      item.index = req_tdata[9:2];
      case (req_tdata[1:0])
         CMD_INIT:  item.op = OP_INIT;
         CMD_ALLOC: item.op = OP_ALLOC;
         CMD_FREE:  item.op = OP_FREE;
         default:   item.op = OP_NONE;
      endcase
   end

   // no intake while the link memory is being rebuilt
   assign req_tready = (fill_ff != 2'd2) && !sweeping;
   assign accept     = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   // queue pointers and fill
   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({accept, q_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[rtl/core/flpa_back.sv]
// ---------------------------------------------------------------------------
// flpa_back
// Executes queued operations on the free list and registers each result.
// ---------------------------------------------------------------------------
module flpa_back #(
   parameter int POOL_DEPTH = flpa_pkg::POOL_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  flpa_pkg::work_type  q_item,
   output logic                q_pop,
   output logic                sweeping,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [8:0]          csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata
);
   import flpa_pkg::*;

   localparam int MEM_DEPTH = (POOL_DEPTH < RANGE_HIGH) ? POOL_DEPTH : RANGE_HIGH;
   localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
   localparam int IDX_W     = $clog2(MEM_DEPTH);
   localparam logic [CNT_W-1:0] POOL_MAX  = CNT_W'(MEM_DEPTH);
   localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MEM_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ALLOC = 4'b0010,
      S_FREE  = 4'b0100,
      S_SWEEP = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     pool_ff, pool_in;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]     act_cnt_ff, act_cnt_in;
   logic [CNT_W-1:0]     sweep_ff, sweep_in;
   logic [8:0]           item_count_ff;
   logic [CNT_W-1:0]     links_ff [MEM_DEPTH];
   logic [CNT_W-1:0]     link_rd_ff;
   logic                 marks_ff [MEM_DEPTH];
   logic                 mark_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     clamp_size;
   logic [CNT_W-1:0]     sweep_next;
   logic                 out_free;
   logic                 load;
   logic [1:0]           res_status;
   logic [7:0]           res_index;
   logic                 mem_we, mem_re;
   logic [IDX_W-1:0]     mem_waddr;
   logic [CNT_W-1:0]     mem_wdata;
   logic                 mark_we, mark_re;
   logic [IDX_W-1:0]     mark_waddr;
   logic                 mark_wdata;

   assign csr_ready = 1'b1;
   assign sweeping  = (state_ff == S_SWEEP);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign sweep_next = sweep_ff + CNT_W'(1);

   // pool size taken at init, clamped to the legal range
   always_comb begin
      if (item_count_ff < 9'(MIN_POOL)) begin
         clamp_size = CNT_W'(MIN_POOL);
      end else if (item_count_ff > 9'(MEM_DEPTH)) begin
         clamp_size = POOL_MAX;
      end else begin
         clamp_size = CNT_W'(item_count_ff);
      end
   end

   // execution control
   always_comb begin
      state_in    = state_ff;
      pool_in     = pool_ff;
      head_in     = head_ff;
      free_cnt_in = free_cnt_ff;
      act_cnt_in  = act_cnt_ff;
      sweep_in    = sweep_ff;
      q_pop       = 1'b0;
      load        = 1'b0;
      res_status  = STS_OK;
      res_index   = 8'd0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = sweep_ff[IDX_W-1:0];
      mem_wdata   = (sweep_next == pool_ff) ? NULL_LINK : sweep_next;
      mark_we     = 1'b0;
      mark_re     = 1'b0;
      mark_waddr  = sweep_ff[IDX_W-1:0];
      mark_wdata  = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_item.op)
                  OP_INIT: begin
                     pool_in     = clamp_size;
                     head_in     = '0;
                     free_cnt_in = clamp_size;
                     act_cnt_in  = '0;
                     sweep_in    = '0;
                     state_in    = S_SWEEP;
                     load        = 1'b1;
                  end
                  OP_ALLOC: begin
                     if (head_ff >= pool_ff) begin
                        res_status = STS_EMPTY;
                        load       = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_ALLOC;
                     end
                  end
                  OP_FREE: begin
                     if ({1'b0, q_item.index} >= 9'(pool_ff)) begin
                        res_status = STS_RANGE;
                        load       = 1'b1;
                     end else begin
                        // item stays queued until its free mark is back
                        q_pop    = 1'b0;
                        mark_re  = 1'b1;
                        state_in = S_FREE;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            // link of the old head has arrived: pop it
            if (out_free) begin
               head_in    = link_rd_ff;
               mark_we    = 1'b1;
               mark_waddr = head_ff[IDX_W-1:0];
               mark_wdata = 1'b0;
               if (free_cnt_ff != '0) begin
                  free_cnt_in = free_cnt_ff - CNT_W'(1);
               end
               act_cnt_in = act_cnt_ff + CNT_W'(1);
               res_index  = 8'(head_ff);
               load       = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FREE: begin
            // free mark of the entry has arrived: reject or push
            if (out_free) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               state_in = S_IDLE;
               if (mark_rd_ff) begin
                  res_status = STS_ALREADY_FREE;
               end else begin
                  mem_we      = 1'b1;
                  mem_waddr   = q_item.index[IDX_W-1:0];
                  mem_wdata   = head_ff;
                  head_in     = CNT_W'(q_item.index);
                  mark_we     = 1'b1;
                  mark_waddr  = q_item.index[IDX_W-1:0];
                  mark_wdata  = 1'b1;
                  free_cnt_in = free_cnt_ff + CNT_W'(1);
                  if (act_cnt_ff != '0) begin
                     act_cnt_in = act_cnt_ff - CNT_W'(1);
                  end
               end
            end
         end
         S_SWEEP: begin
            // relink entries in ascending order, last one null, all marked free
            mem_we   = 1'b1;
            mark_we  = 1'b1;
            sweep_in = sweep_next;
            if (sweep_next == pool_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in.status       = res_status;
      rsp_data_in.index        = res_index;
      rsp_data_in.free_count   = 9'(free_cnt_in);
      rsp_data_in.active_count = 9'(act_cnt_in);
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         pool_ff       <= POOL_MAX;
         head_ff       <= '0;
         free_cnt_ff   <= POOL_MAX;
         act_cnt_ff    <= '0;
         sweep_ff      <= '0;
         item_count_ff <= 9'(RANGE_HIGH);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         head_ff      <= head_in;
         free_cnt_ff  <= free_cnt_in;
         act_cnt_ff   <= act_cnt_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            item_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // next-link memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         links_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         link_rd_ff <= links_ff[head_ff[IDX_W-1:0]];
      end
   end

   // free-mark memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mark_we) begin
         marks_ff[mark_waddr] <= mark_wdata;
      end
      if (mark_re) begin
         mark_rd_ff <= marks_ff[q_item.index[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff.active_count, rsp_data_ff.free_count,
                        rsp_data_ff.index, rsp_data_ff.status};

endmodule

[rtl/core/flpa_checker.sv]
// ---------------------------------------------------------------------------
// flpa_checker
// Port-level checks on the result stream of the pool allocator.
// ---------------------------------------------------------------------------
`include "free_list_pool_allocator_assert.svh"

module flpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   `FLPA_ASSERT(a_rsp_hold, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")

   // free and active counts always add up to at most 256, the largest pool
   `FLPA_ASSERT(a_count_sum, reset, rsp_tvalid |-> ({1'b0, rsp_tdata[18:10]} + {1'b0, rsp_tdata[27:19]}) <= 10'd256, "counts exceed pool")

   // empty status only when nothing is on the free list
   `FLPA_ASSERT(a_empty_count, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd1 |-> rsp_tdata[18:10] == 9'd0, "empty with free entries")

   // a nonzero index is only returned with ok status
   `FLPA_ASSERT(a_index_ok, reset, rsp_tvalid && rsp_tdata[9:2] != 8'd0 |-> rsp_tdata[1:0] == 2'd0, "index on failed command")

   // no result is offered right after reset
   `FLPA_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

endmodule

bind free_list_pool_allocator flpa_checker u_flpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
